// ===== design/i2cm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master byte engine: command codes,
// the classified command item, the result item and the configuration set.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   // Command codes as they arrive on the mode field.
   localparam logic [2:0] MODE_START     = 3'd0;
   localparam logic [2:0] MODE_WRITE     = 3'd1;
   localparam logic [2:0] MODE_READ_ACK  = 3'd2;
   localparam logic [2:0] MODE_READ_NACK = 3'd3;
   localparam logic [2:0] MODE_STOP      = 3'd4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_HALF_DELAY = 2'd0;
   localparam logic [1:0] CSR_ACK_SETTLE = 2'd1;
   localparam logic [1:0] CSR_HOLD       = 2'd2;

   localparam int unsigned HALF_WIDTH = 16;
   localparam int unsigned HOLD_WIDTH = 24;

   // Two-entry queues: one pointer bit, a count that can hold the depth.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

   // Classified command: no command, or one of the five known kinds.
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_START,
      CMD_WRITE,
      CMD_READ_ACK,
      CMD_READ_NACK,
      CMD_STOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   tx_byte;
      logic         hold_after;
      logic         sda_in;
      logic         scl_in;
   } item_type;

   typedef struct packed {
      logic       scl_pull_low;
      logic       sda_pull_low;
      logic       busy_res;
      logic       done_res;
      logic       ack_ok;
      logic [7:0] rx_byte;
   } rsp_type;

   typedef struct packed {
      logic [HALF_WIDTH-1:0] half_delay_ticks;
      logic [HALF_WIDTH-1:0] ack_settle_ticks;
      logic [HOLD_WIDTH-1:0] hold_ticks;
   } cfg_type;

endpackage

// ===== design/i2cm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts tick items, decodes the command field into a command kind and
// keeps them in a two-entry queue until the bus engine takes them.
// ----------------------------------------------------------------------------
module i2cm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic                cmd_valid,
   input  logic [2:0]          mode,
   input  logic [7:0]          tx_byte,
   input  logic                hold_after,
   input  logic                sda_in,
   input  logic                scl_in,
   input  logic                take,
   output logic                item_valid,
   output i2cm_pkg::item_type  item
);

   i2cm_pkg::item_type                      queue_ff [i2cm_pkg::QUEUE_DEPTH];
   logic [i2cm_pkg::PTR_WIDTH-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [i2cm_pkg::PTR_WIDTH-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [i2cm_pkg::CNT_WIDTH-1:0]          count_ff, count_in;
   i2cm_pkg::cmd_kind_type                  kind;
   i2cm_pkg::item_type                      new_item;
   logic                                    do_push, do_pop;

   // Invalid ticks and unknown modes both become "no command".
   always_comb begin
      kind = i2cm_pkg::CMD_NONE;
      if (cmd_valid) begin
         unique case (mode)
            i2cm_pkg::MODE_START:     kind = i2cm_pkg::CMD_START;
            i2cm_pkg::MODE_WRITE:     kind = i2cm_pkg::CMD_WRITE;
            i2cm_pkg::MODE_READ_ACK:  kind = i2cm_pkg::CMD_READ_ACK;
            i2cm_pkg::MODE_READ_NACK: kind = i2cm_pkg::CMD_READ_NACK;
            i2cm_pkg::MODE_STOP:      kind = i2cm_pkg::CMD_STOP;
            default:                  kind = i2cm_pkg::CMD_NONE;
         endcase
      end
   end

   assign new_item = '{kind: kind, tx_byte: tx_byte, hold_after: hold_after,
                       sda_in: sda_in, scl_in: scl_in};

   assign full       = (count_ff == i2cm_pkg::CNT_WIDTH'(i2cm_pkg::QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = take && item_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== design/i2cm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_core
// Bus sequencer: advances the SCL/SDA phase machine by one tick per item it
// takes and produces one result item per tick.
// ----------------------------------------------------------------------------
module i2cm_core #(
   parameter int unsigned WAIT_WIDTH = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  i2cm_pkg::cfg_type  cfg,
   input  logic               step,
   input  i2cm_pkg::item_type item,
   output i2cm_pkg::rsp_type  rsp
);

   typedef enum logic [4:0] {
      PH_IDLE, PH_ST1, PH_ST2, PH_W_DATA, PH_W_HIGH, PH_W_LOW, PH_W_ACK,
      PH_W_END, PH_W_HOLD, PH_R_HIGH, PH_R_LOW, PH_RA_HIGH, PH_RA_LOW,
      PH_RN_HIGH, PH_RN_LOW, PH_RN_REL, PH_RN_WAIT, PH_SP1, PH_SP2
   } phase_type;

   typedef enum logic [1:0] {
      DLY_HALF,
      DLY_ACK,
      DLY_HOLD
   } delay_sel_type;

   // Delays are at most 24 bits; one more bit keeps the sum of half delay
   // and settle time without overflow.
   localparam int unsigned DLY_WIDTH = i2cm_pkg::HOLD_WIDTH + 1;
   localparam int unsigned CMP_WIDTH = WAIT_WIDTH + DLY_WIDTH;

   phase_type               phase_ff, phase_in;
   logic [3:0]              bit_count_ff, bit_count_in;
   logic [WAIT_WIDTH-1:0]   wait_ff, wait_in;
   logic [7:0]              shift_ff, shift_in;
   i2cm_pkg::cmd_kind_type  kind_ff, kind_in;
   logic                    hold_ff, hold_in;
   logic                    scl_ff, scl_in;
   logic                    sda_ff, sda_in;
   logic                    ack_ff, ack_in;
   logic [7:0]              rx_ff, rx_in;
   logic                    done_in;

   logic [i2cm_pkg::HALF_WIDTH-1:0] half;
   logic [3:0]                      bit_next;
   logic                            load_wait;
   delay_sel_type                   delay_sel;
   logic [DLY_WIDTH-1:0]            delay;
   logic [DLY_WIDTH-1:0]            delay_m1;
   logic [CMP_WIDTH-1:0]            delay_ext;
   logic [CMP_WIDTH-1:0]            wait_max;
   logic [WAIT_WIDTH-1:0]           wait_load;

   // A half delay of zero behaves as one tick.
   assign half     = (cfg.half_delay_ticks == '0) ? i2cm_pkg::HALF_WIDTH'(1)
                                                  : cfg.half_delay_ticks;
   assign bit_next = bit_count_ff + 4'd1;

   // Phase length in ticks, minus the entry tick, saturated to the counter.
   always_comb begin
      case (delay_sel)
         DLY_ACK:  delay = DLY_WIDTH'(half) + DLY_WIDTH'(cfg.ack_settle_ticks);
         DLY_HOLD: delay = DLY_WIDTH'(cfg.hold_ticks);
         default:  delay = DLY_WIDTH'(half);
      endcase
   end

   assign delay_m1  = delay - DLY_WIDTH'(1);
   assign delay_ext = CMP_WIDTH'(delay_m1);
   assign wait_max  = CMP_WIDTH'({WAIT_WIDTH{1'b1}});
   assign wait_load = (delay_ext > wait_max) ? {WAIT_WIDTH{1'b1}}
                                             : delay_ext[WAIT_WIDTH-1:0];

   always_comb begin
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      wait_in      = wait_ff;
      shift_in     = shift_ff;
      kind_in      = kind_ff;
      hold_in      = hold_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      ack_in       = ack_ff;
      rx_in        = rx_ff;
      done_in      = 1'b0;
      load_wait    = 1'b0;
      delay_sel    = DLY_HALF;

      if (phase_ff == PH_IDLE) begin
         if (item.kind != i2cm_pkg::CMD_NONE) begin
            kind_in      = item.kind;
            bit_count_in = '0;
            load_wait    = 1'b1;
            case (item.kind)
               i2cm_pkg::CMD_START: begin
                  scl_in   = 1'b0;
                  sda_in   = 1'b1;
                  phase_in = PH_ST1;
               end
               i2cm_pkg::CMD_WRITE: begin
                  shift_in = item.tx_byte;
                  hold_in  = item.hold_after;
                  sda_in   = !item.tx_byte[7];
                  phase_in = PH_W_DATA;
               end
               i2cm_pkg::CMD_STOP: begin
                  sda_in   = 1'b1;
                  phase_in = PH_SP1;
               end
               default: begin
                  shift_in = '0;
                  sda_in   = 1'b0;
                  scl_in   = 1'b0;
                  phase_in = PH_R_HIGH;
               end
            endcase
         end
      end else if (phase_ff == PH_RN_WAIT) begin
         // Slave may stretch the clock: wait for SCL to come back high.
         if (item.scl_in) begin
            rx_in    = shift_ff;
            phase_in = PH_IDLE;
            done_in  = 1'b1;
         end
      end else if (wait_ff != '0) begin
         wait_in = wait_ff - 1'b1;
      end else begin
         unique case (phase_ff)
            PH_ST1: begin
               scl_in    = 1'b1;
               phase_in  = PH_ST2;
               load_wait = 1'b1;
            end
            PH_W_DATA: begin
               scl_in    = 1'b0;
               phase_in  = PH_W_HIGH;
               load_wait = 1'b1;
            end
            PH_W_HIGH: begin
               scl_in    = 1'b1;
               shift_in  = {shift_ff[6:0], 1'b0};
               phase_in  = PH_W_LOW;
               load_wait = 1'b1;
            end
            PH_W_LOW: begin
               bit_count_in = bit_next;
               load_wait    = 1'b1;
               if (bit_next < 4'd8) begin
                  sda_in   = !shift_ff[7];
                  phase_in = PH_W_DATA;
               end else begin
                  sda_in    = 1'b0;
                  scl_in    = 1'b0;
                  phase_in  = PH_W_ACK;
                  delay_sel = DLY_ACK;
               end
            end
            PH_W_ACK: begin
               if (item.sda_in) begin
                  ack_in   = 1'b0;
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end else begin
                  ack_in    = 1'b1;
                  scl_in    = 1'b1;
                  sda_in    = 1'b1;
                  phase_in  = PH_W_END;
                  load_wait = 1'b1;
               end
            end
            PH_W_END: begin
               if (hold_ff && (cfg.hold_ticks != '0)) begin
                  phase_in  = PH_W_HOLD;
                  load_wait = 1'b1;
                  delay_sel = DLY_HOLD;
               end else begin
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end
            end
            PH_R_HIGH: begin
               shift_in  = {shift_ff[6:0], item.sda_in};
               scl_in    = 1'b1;
               phase_in  = PH_R_LOW;
               load_wait = 1'b1;
            end
            PH_R_LOW: begin
               bit_count_in = bit_next;
               scl_in       = 1'b0;
               load_wait    = 1'b1;
               if (bit_next < 4'd8) begin
                  phase_in = PH_R_HIGH;
               end else if (kind_ff == i2cm_pkg::CMD_READ_ACK) begin
                  sda_in   = 1'b1;
                  phase_in = PH_RA_HIGH;
               end else begin
                  sda_in   = 1'b0;
                  phase_in = PH_RN_HIGH;
               end
            end
            PH_RA_HIGH: begin
               scl_in    = 1'b1;
               phase_in  = PH_RA_LOW;
               load_wait = 1'b1;
            end
            PH_RA_LOW: begin
               sda_in   = 1'b0;
               rx_in    = shift_ff;
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
            PH_RN_HIGH: begin
               scl_in    = 1'b1;
               phase_in  = PH_RN_LOW;
               load_wait = 1'b1;
            end
            PH_RN_LOW: begin
               scl_in    = 1'b0;
               phase_in  = PH_RN_REL;
               load_wait = 1'b1;
            end
            PH_RN_REL: begin
               if (item.scl_in) begin
                  rx_in    = shift_ff;
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end else begin
                  phase_in = PH_RN_WAIT;
               end
            end
            PH_SP1: begin
               scl_in    = 1'b0;
               phase_in  = PH_SP2;
               load_wait = 1'b1;
            end
            PH_SP2: begin
               sda_in   = 1'b0;
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
            default: begin
               // End of the start condition or of a hold.
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
         endcase
      end

      if (load_wait) begin
         wait_in = wait_load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_count_ff <= '0;
         wait_ff      <= '0;
         shift_ff     <= '0;
         kind_ff      <= i2cm_pkg::CMD_NONE;
         hold_ff      <= 1'b0;
         scl_ff       <= 1'b0;
         sda_ff       <= 1'b0;
         ack_ff       <= 1'b0;
         rx_ff        <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         wait_ff      <= wait_in;
         shift_ff     <= shift_in;
         kind_ff      <= kind_in;
         hold_ff      <= hold_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         ack_ff       <= ack_in;
         rx_ff        <= rx_in;
      end
   end

   // Result of this tick, taken by the result queue together with step.
   assign rsp = '{scl_pull_low: scl_in, sda_pull_low: sda_in,
                  busy_res: (phase_in != PH_IDLE), done_res: done_in,
                  ack_ok: ack_in, rx_byte: rx_in};

endmodule

// ===== design/i2cm_rsp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_rsp_queue
// Two-entry result queue between the bus engine and the result port.
// ----------------------------------------------------------------------------
module i2cm_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  i2cm_pkg::rsp_type  wr_data,
   output logic               full,
   output logic               empty,
   input  logic               pop,
   output i2cm_pkg::rsp_type  rd_data
);

   i2cm_pkg::rsp_type                 queue_ff [i2cm_pkg::QUEUE_DEPTH];
   logic [i2cm_pkg::PTR_WIDTH-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [i2cm_pkg::PTR_WIDTH-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [i2cm_pkg::CNT_WIDTH-1:0]    count_ff, count_in;
   logic                              do_push, do_pop;

   assign full    = (count_ff == i2cm_pkg::CNT_WIDTH'(i2cm_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = queue_ff[rd_ptr_ff];
   assign do_push = wr_en && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== design/i2c_master_byte_engine.sv =====
`timescale 1ns / 1ps
// An accepted item waits in the front queue until the bus engine steps it; its
// result is then written into the result queue, whose head drives the rsp_ ports
// and can be popped, when neither queue is backed up.
// Throughput: one item per cycle while the result queue has a free slot, set by the single-tick step of the bus engine.
// Reset (synchronous, active high) empties both queues, returns the engine to
// idle with both bus lines released and loads the register defaults.
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Open-drain I2C master byte engine. Each input item is one timing tick that
// carries an optional command and the sampled bus levels; each tick yields one
// result item with the line drives and status.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine #(
   parameter int unsigned WAIT_WIDTH = 24
) (
   input  logic        clock,
   input  logic        reset,

   // Tick items in.
   input  logic        push,
   output logic        full,
   input  logic        req_cmd_valid,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_tx_byte,
   input  logic        req_hold_after,
   input  logic        req_sda_in,
   input  logic        req_scl_in,

   // Result items out.
   output logic        empty,
   input  logic        pop,
   output logic        rsp_scl_pull_low,
   output logic        rsp_sda_pull_low,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic        rsp_ack_ok,
   output logic [7:0]  rsp_rx_byte,

   // Register writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);

   i2cm_pkg::cfg_type  cfg_ff, cfg_in;
   i2cm_pkg::item_type item;
   i2cm_pkg::rsp_type  core_rsp;
   i2cm_pkg::rsp_type  out_rsp;
   logic               item_valid;
   logic               rsp_full;
   logic               step;

   // Registers are always writable; writes to an unused index are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            i2cm_pkg::CSR_HALF_DELAY:
               cfg_in.half_delay_ticks = csr_data[i2cm_pkg::HALF_WIDTH-1:0];
            i2cm_pkg::CSR_ACK_SETTLE:
               cfg_in.ack_settle_ticks = csr_data[i2cm_pkg::HALF_WIDTH-1:0];
            i2cm_pkg::CSR_HOLD:
               cfg_in.hold_ticks = csr_data[i2cm_pkg::HOLD_WIDTH-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_delay_ticks <= i2cm_pkg::HALF_WIDTH'(50);
         cfg_ff.ack_settle_ticks <= i2cm_pkg::HALF_WIDTH'(4);
         cfg_ff.hold_ticks       <= i2cm_pkg::HOLD_WIDTH'(1000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front queue decouples accepted ticks from the bus engine, so an
   // item is taken even while a result waits for the consumer.
   i2cm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .cmd_valid  (req_cmd_valid),
      .mode       (req_mode),
      .tx_byte    (req_tx_byte),
      .hold_after (req_hold_after),
      .sda_in     (req_sda_in),
      .scl_in     (req_scl_in),
      .take       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   // The engine advances exactly one tick for every item it takes, and only
   // when the result queue has a free slot for that tick's result.
   assign step = item_valid && !rsp_full;

   i2cm_core #(
      .WAIT_WIDTH (WAIT_WIDTH)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .step  (step),
      .item  (item),
      .rsp   (core_rsp)
   );

   i2cm_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (step),
      .wr_data (core_rsp),
      .full    (rsp_full),
      .empty   (empty),
      .pop     (pop),
      .rd_data (out_rsp)
   );

   assign rsp_scl_pull_low = out_rsp.scl_pull_low;
   assign rsp_sda_pull_low = out_rsp.sda_pull_low;
   assign rsp_busy_res     = out_rsp.busy_res;
   assign rsp_done_res     = out_rsp.done_res;
   assign rsp_ack_ok       = out_rsp.ack_ok;
   assign rsp_rx_byte      = out_rsp.rx_byte;

endmodule

// ===== verif/tb_i2c_master_byte_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_byte_engine
// Self-checking bench for the I2C master byte engine. Each pushed item is one
// timing tick. A cycle-true engine model in the bench predicts the line drives
// and status of every tick, and each popped result is compared field by field.
// ----------------------------------------------------------------------------
module tb_i2c_master_byte_engine;

   localparam int unsigned QUIET_LIMIT     = 5000;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned PLAN_AHEAD      = 64;
   localparam int unsigned RANDOM_TICKS    = 300;
   localparam int unsigned WAIT_MAX        = 24'hFFFFFF;
   localparam logic [23:0] HOLD_MAX        = 24'hFFFFFF;
   localparam logic [2:0]  MODE_LAST_CODE  = 3'd7;

   // Bus sequencing steps of the engine, one per line-level plateau.
   typedef enum logic [4:0] {
      S_IDLE, S_START_SDA, S_START_SCL,
      S_WR_BIT, S_WR_HIGH, S_WR_LOW, S_WR_ACK, S_WR_END, S_WR_HOLD,
      S_RD_HIGH, S_RD_LOW, S_RA_HIGH, S_RA_LOW,
      S_RN_HIGH, S_RN_LOW, S_RN_RELEASE, S_RN_STRETCH,
      S_STOP_SCL, S_STOP_SDA
   } eng_phase_type;

   typedef struct packed {
      eng_phase_type phase;
      logic [3:0]    bits;
      logic [23:0]   wait_left;
      logic [7:0]    shreg;
      logic [2:0]    cmd;
      logic          hold;
      logic          scl_low;
      logic          sda_low;
      logic          acked;
      logic [7:0]    rx;
   } engine_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] mode;
      logic [7:0] tx_byte;
      logic       hold_after;
      logic       sda_in;
      logic       scl_in;
   } tick_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_cmd_valid = 1'b0;
   logic [2:0]  req_mode = '0;
   logic [7:0]  req_tx_byte = '0;
   logic        req_hold_after = 1'b0;
   logic        req_sda_in = 1'b0;
   logic        req_scl_in = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic        rsp_scl_pull_low;
   logic        rsp_sda_pull_low;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic        rsp_ack_ok;
   logic [7:0]  rsp_rx_byte;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [23:0] csr_data = '0;

   i2c_master_byte_engine u_top (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_cmd_valid    (req_cmd_valid),
      .req_mode         (req_mode),
      .req_tx_byte      (req_tx_byte),
      .req_hold_after   (req_hold_after),
      .req_sda_in       (req_sda_in),
      .req_scl_in       (req_scl_in),
      .empty            (empty),
      .pop              (pop),
      .rsp_scl_pull_low (rsp_scl_pull_low),
      .rsp_sda_pull_low (rsp_sda_pull_low),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_ack_ok       (rsp_ack_ok),
      .rsp_rx_byte      (rsp_rx_byte),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #4 clock = ~clock;

   // Register values that the model runs with; they only change while the
   // engine is idle and nothing is in flight.
   i2cm_pkg::cfg_type cfg_now = '{half_delay_ticks: 16'd50, ack_settle_ticks: 16'd4,
                                  hold_ticks: 24'd1000};

   // Two copies of the engine state: the planner steps its own copy as it
   // builds ticks, so it knows where the sample points fall; the checker
   // steps the other copy as ticks are actually accepted.
   engine_type plan_st;
   engine_type chk_st;

   tick_type          tick_q[$];
   tick_type          cur_tick;
   i2cm_pkg::rsp_type line_state_q[$];

   int unsigned send_idle_pct = 0;
   int unsigned rcv_idle_pct = 0;
   int unsigned stretch_pct = 50;
   logic        nack_at_ack = 1'b0;
   int unsigned stall_asked = 0;
   int unsigned stall_served = 0;
   int unsigned stall_left = 0;
   int unsigned quiet_cycles = 0;

   int unsigned n_planned = 0;
   int unsigned n_ticks = 0;
   int unsigned n_results = 0;
   int unsigned n_cmds = 0;
   int unsigned n_done = 0;
   int unsigned n_acked = 0;
   int unsigned n_nacked = 0;
   int unsigned n_reg_writes = 0;
   int unsigned n_errors = 0;

   function automatic engine_type idle_engine();
      engine_type s;
      s = '0;
      s.phase = S_IDLE;
      return s;
   endfunction

   // Enter a bus step that lasts the given number of ticks, the entry tick
   // included. Zero is treated as one and the counter saturates.
   function automatic void go_phase(inout engine_type s, input eng_phase_type p,
                                    input int unsigned ticks);
      int unsigned d;
      d = (ticks == 0) ? 0 : ticks - 1;
      if (d > WAIT_MAX) d = WAIT_MAX;
      s.phase = p;
      s.wait_left = d[23:0];
   endfunction

   // One timing tick of the engine: returns the line drives and status.
   function automatic i2cm_pkg::rsp_type engine_tick(inout engine_type s,
                                                     input tick_type t);
      int unsigned       h;
      logic              done;
      i2cm_pkg::rsp_type r;
      h = (cfg_now.half_delay_ticks == 0) ? 1 : cfg_now.half_delay_ticks;
      done = 1'b0;
      if (s.phase == S_IDLE) begin
         if (t.cmd_valid && t.mode <= i2cm_pkg::MODE_STOP) begin
            s.cmd = t.mode;
            s.bits = '0;
            case (t.mode)
               i2cm_pkg::MODE_START: begin
                  s.scl_low = 1'b0;
                  s.sda_low = 1'b1;
                  go_phase(s, S_START_SDA, h);
               end
               i2cm_pkg::MODE_WRITE: begin
                  s.shreg = t.tx_byte;
                  s.hold = t.hold_after;
                  s.sda_low = ~t.tx_byte[7];
                  go_phase(s, S_WR_BIT, h);
               end
               i2cm_pkg::MODE_STOP: begin
                  s.sda_low = 1'b1;
                  go_phase(s, S_STOP_SCL, h);
               end
               default: begin
                  s.shreg = '0;
                  s.sda_low = 1'b0;
                  s.scl_low = 1'b0;
                  go_phase(s, S_RD_HIGH, h);
               end
            endcase
         end
      end else if (s.phase == S_RN_STRETCH) begin
         // The slave holds SCL low; finish as soon as the line is seen high.
         if (t.scl_in) begin
            s.rx = s.shreg;
            s.phase = S_IDLE;
            done = 1'b1;
         end
      end else if (s.wait_left != 0) begin
         s.wait_left = s.wait_left - 1;
      end else begin
         case (s.phase)
            S_START_SDA: begin
               s.scl_low = 1'b1;
               go_phase(s, S_START_SCL, h);
            end
            S_WR_BIT: begin
               s.scl_low = 1'b0;
               go_phase(s, S_WR_HIGH, h);
            end
            S_WR_HIGH: begin
               s.scl_low = 1'b1;
               s.shreg = {s.shreg[6:0], 1'b0};
               go_phase(s, S_WR_LOW, h);
            end
            S_WR_LOW: begin
               s.bits = s.bits + 1;
               if (s.bits < 8) begin
                  s.sda_low = ~s.shreg[7];
                  go_phase(s, S_WR_BIT, h);
               end else begin
                  // Ninth clock: release SDA and wait the extra settle time.
                  s.sda_low = 1'b0;
                  s.scl_low = 1'b0;
                  go_phase(s, S_WR_ACK, h + cfg_now.ack_settle_ticks);
               end
            end
            S_WR_ACK: begin
               if (t.sda_in) begin
                  s.acked = 1'b0;
                  s.phase = S_IDLE;
                  done = 1'b1;
               end else begin
                  s.acked = 1'b1;
                  s.scl_low = 1'b1;
                  s.sda_low = 1'b1;
                  go_phase(s, S_WR_END, h);
               end
            end
            S_WR_END: begin
               if (s.hold && cfg_now.hold_ticks != 0) begin
                  go_phase(s, S_WR_HOLD, cfg_now.hold_ticks);
               end else begin
                  s.phase = S_IDLE;
                  done = 1'b1;
               end
            end
            S_RD_HIGH: begin
               s.shreg = {s.shreg[6:0], t.sda_in};
               s.scl_low = 1'b1;
               go_phase(s, S_RD_LOW, h);
            end
            S_RD_LOW: begin
               s.bits = s.bits + 1;
               s.scl_low = 1'b0;
               if (s.bits < 8) begin
                  go_phase(s, S_RD_HIGH, h);
               end else if (s.cmd == i2cm_pkg::MODE_READ_ACK) begin
                  s.sda_low = 1'b1;
                  go_phase(s, S_RA_HIGH, h);
               end else begin
                  s.sda_low = 1'b0;
                  go_phase(s, S_RN_HIGH, h);
               end
            end
            S_RA_HIGH: begin
               s.scl_low = 1'b1;
               go_phase(s, S_RA_LOW, h);
            end
            S_RA_LOW: begin
               s.sda_low = 1'b0;
               s.rx = s.shreg;
               s.phase = S_IDLE;
               done = 1'b1;
            end
            S_RN_HIGH: begin
               s.scl_low = 1'b1;
               go_phase(s, S_RN_LOW, h);
            end
            S_RN_LOW: begin
               s.scl_low = 1'b0;
               go_phase(s, S_RN_RELEASE, h);
            end
            S_RN_RELEASE: begin
               if (t.scl_in) begin
                  s.rx = s.shreg;
                  s.phase = S_IDLE;
                  done = 1'b1;
               end else begin
                  s.phase = S_RN_STRETCH;
               end
            end
            S_STOP_SCL: begin
               s.scl_low = 1'b0;
               go_phase(s, S_STOP_SDA, h);
            end
            S_STOP_SDA: begin
               s.sda_low = 1'b0;
               s.phase = S_IDLE;
               done = 1'b1;
            end
            default: begin
               // End of the start condition and end of a hold.
               s.phase = S_IDLE;
               done = 1'b1;
            end
         endcase
      end
      r.scl_pull_low = s.scl_low;
      r.sda_pull_low = s.sda_low;
      r.busy_res     = (s.phase != S_IDLE);
      r.done_res     = done;
      r.ack_ok       = s.acked;
      r.rx_byte      = s.rx;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      n_errors++;
      $display("mismatch at result %0d: %s is %0d, expected %0d",
               n_results, what, got, want);
   endtask

   // ------------------------------------------------------------------------
   // Driver: offers queued ticks with random gaps and runs the checker's copy
   // of the engine on every tick the block accepts.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      i2cm_pkg::rsp_type want;
      logic              offering;
      if (reset) begin
         push <= 1'b0;
      end else begin
         offering = push;
         if (push && !full) begin
            want = engine_tick(chk_st, cur_tick);
            line_state_q.push_back(want);
            n_ticks++;
            if (want.done_res) n_done++;
            offering = 1'b0;
         end
         if (!offering) begin
            if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_tick = tick_q.pop_front();
               req_cmd_valid  <= cur_tick.cmd_valid;
               req_mode       <= cur_tick.mode;
               req_tx_byte    <= cur_tick.tx_byte;
               req_hold_after <= cur_tick.hold_after;
               req_sda_in     <= cur_tick.sda_in;
               req_scl_in     <= cur_tick.scl_in;
               push <= 1'b1;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: compares each popped result with the oldest prediction. The
   // receiver pops at random, and on request holds off for a long stretch so
   // that both internal queues fill and the input side stalls.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      i2cm_pkg::rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            n_results++;
            if (line_state_q.size() == 0) begin
               report_mismatch("result with nothing predicted, busy", rsp_busy_res, 0);
            end else begin
               want = line_state_q.pop_front();
               if (rsp_scl_pull_low !== want.scl_pull_low)
                  report_mismatch("scl_pull_low", rsp_scl_pull_low, want.scl_pull_low);
               if (rsp_sda_pull_low !== want.sda_pull_low)
                  report_mismatch("sda_pull_low", rsp_sda_pull_low, want.sda_pull_low);
               if (rsp_busy_res !== want.busy_res)
                  report_mismatch("busy_res", rsp_busy_res, want.busy_res);
               if (rsp_done_res !== want.done_res)
                  report_mismatch("done_res", rsp_done_res, want.done_res);
               if (rsp_ack_ok !== want.ack_ok)
                  report_mismatch("ack_ok", rsp_ack_ok, want.ack_ok);
               if (rsp_rx_byte !== want.rx_byte)
                  report_mismatch("rx_byte", rsp_rx_byte, want.rx_byte);
            end
         end
         if (stall_served != stall_asked) begin
            stall_served = stall_asked;
            stall_left = HOLD_OFF_CYCLES;
         end
         if (stall_left != 0) begin
            stall_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   // Cycles in which no item, result or register write was accepted.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus planning. All queue work happens on the falling edge so that it
   // never races the clocked driver and monitor.
   // ------------------------------------------------------------------------

   // Build one tick and step the planner's engine copy with it. The data line
   // is forced at the acknowledge sample point, and the clock line level in the
   // final wait of a NACK read follows the current stretch probability.
   task automatic plan_tick(input logic cv, input logic [2:0] md,
                            input logic [7:0] tb, input logic ha);
      tick_type t;
      while (tick_q.size() >= PLAN_AHEAD) @(negedge clock);
      t.cmd_valid  = cv;
      t.mode       = md;
      t.tx_byte    = tb;
      t.hold_after = ha;
      t.sda_in     = 1'($urandom_range(1));
      t.scl_in     = 1'($urandom_range(1));
      if (plan_st.phase == S_WR_ACK && plan_st.wait_left == 0)
         t.sda_in = nack_at_ack;
      if (plan_st.phase == S_RN_RELEASE || plan_st.phase == S_RN_STRETCH)
         t.scl_in = ($urandom_range(99) >= stretch_pct);
      void'(engine_tick(plan_st, t));
      tick_q.push_back(t);
      n_planned++;
   endtask

   // A few noise ticks, the command, then busy ticks until the engine is idle
   // again. Some busy ticks carry a command, which the engine must ignore.
   task automatic issue(input logic [2:0] md, input logic [7:0] tb,
                        input logic ha, input logic nack);
      int unsigned gap;
      gap = $urandom_range(2);
      repeat (gap) plan_tick(1'b0, 3'($urandom_range(7)), 8'($urandom), 1'($urandom));
      nack_at_ack = nack;
      plan_tick(1'b1, md, tb, ha);
      n_cmds++;
      if (md == i2cm_pkg::MODE_WRITE) begin
         if (nack) n_nacked++;
         else n_acked++;
      end
      while (plan_st.phase != S_IDLE)
         plan_tick($urandom_range(7) == 0, 3'($urandom_range(7)), 8'($urandom),
                   1'($urandom));
   endtask

   // A well-formed transfer: start, address byte, a few data bytes in either
   // direction, an optional final NACK read, stop.
   task automatic random_transfer();
      int unsigned n_data;
      n_data = $urandom_range(3);
      issue(i2cm_pkg::MODE_START, 8'($urandom), 1'($urandom), 1'b0);
      issue(i2cm_pkg::MODE_WRITE, 8'($urandom), 1'($urandom), $urandom_range(9) == 0);
      repeat (n_data) begin
         if ($urandom_range(2) == 0)
            issue(i2cm_pkg::MODE_READ_ACK, 8'($urandom), 1'($urandom), 1'b0);
         else
            issue(i2cm_pkg::MODE_WRITE, 8'($urandom), 1'($urandom),
                  $urandom_range(4) == 0);
      end
      if ($urandom_range(1))
         issue(i2cm_pkg::MODE_READ_NACK, 8'($urandom), 1'($urandom), 1'b0);
      issue(i2cm_pkg::MODE_STOP, 8'($urandom), 1'($urandom), 1'b0);
   endtask

   // Mostly well-formed transfers, the rest single commands of any code,
   // unknown codes included.
   task automatic run_random(input int unsigned ticks, input logic hold_off);
      int unsigned stop_at;
      int unsigned midway;
      logic        asked;
      stop_at = n_planned + ticks;
      midway = n_planned + ticks / 3;
      asked = 1'b0;
      while (n_planned < stop_at) begin
         if (hold_off && !asked && n_planned >= midway) begin
            stall_asked++;
            asked = 1'b1;
         end
         if ($urandom_range(4) != 0)
            random_transfer();
         else
            issue(3'($urandom_range(MODE_LAST_CODE)), 8'($urandom), 1'($urandom),
                  1'($urandom));
      end
   endtask

   // Sender pause: wait until every planned tick is accepted and every
   // predicted result has been popped, then let the pipeline settle.
   task automatic wait_drained();
      while (tick_q.size() != 0 || push || line_state_q.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         i2cm_pkg::CSR_HALF_DELAY: cfg_now.half_delay_ticks = val[15:0];
         i2cm_pkg::CSR_ACK_SETTLE: cfg_now.ack_settle_ticks = val[15:0];
         i2cm_pkg::CSR_HOLD:       cfg_now.hold_ticks = val;
         default: ;
      endcase
      n_reg_writes++;
      @(negedge clock);
   endtask

   task automatic set_timing(input logic [15:0] half, input logic [15:0] settle,
                             input logic [23:0] hold);
      wait_drained();
      write_reg(i2cm_pkg::CSR_HALF_DELAY, {8'h00, half});
      write_reg(i2cm_pkg::CSR_ACK_SETTLE, {8'h00, settle});
      write_reg(i2cm_pkg::CSR_HOLD, hold);
   endtask

   initial begin : main
      plan_st = idle_engine();
      chk_st  = idle_engine();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values of the registers: a start and a stop at 50 ticks a phase.
      send_idle_pct = 24;
      rcv_idle_pct = 76;
      issue(i2cm_pkg::MODE_START, 8'h00, 1'b0, 1'b0);
      issue(i2cm_pkg::MODE_STOP, 8'hFF, 1'b1, 1'b0);

      // Shortest timing with no settle and no hold: both written byte
      // extremes, acknowledged and refused, a hold request with a zero hold,
      // both reads, a NACK read with and without clock stretching, and the
      // unknown command codes while idle.
      set_timing(16'd1, 16'd0, 24'd0);
      issue(i2cm_pkg::MODE_START, 8'h00, 1'b0, 1'b0);
      issue(i2cm_pkg::MODE_WRITE, 8'h00, 1'b0, 1'b0);
      issue(i2cm_pkg::MODE_WRITE, 8'hFF, 1'b0, 1'b1);
      issue(i2cm_pkg::MODE_WRITE, 8'hA5, 1'b1, 1'b0);
      issue(i2cm_pkg::MODE_READ_ACK, 8'h00, 1'b0, 1'b0);
      stretch_pct = 80;
      issue(i2cm_pkg::MODE_READ_NACK, 8'hFF, 1'b1, 1'b0);
      stretch_pct = 0;
      issue(i2cm_pkg::MODE_READ_NACK, 8'h00, 1'b0, 1'b0);
      for (int m = i2cm_pkg::MODE_STOP + 1; m <= MODE_LAST_CODE; m++)
         issue(3'(m), 8'($urandom), 1'($urandom), 1'b0);
      issue(i2cm_pkg::MODE_STOP, 8'h00, 1'b0, 1'b0);

      // A zero half delay runs as one tick per phase; short holds after
      // acknowledged bytes.
      stretch_pct = 50;
      set_timing(16'd0, 16'd3, 24'd5);
      issue(i2cm_pkg::MODE_START, 8'h00, 1'b0, 1'b0);
      issue(i2cm_pkg::MODE_WRITE, 8'h5A, 1'b1, 1'b0);
      issue(i2cm_pkg::MODE_WRITE, 8'h80, 1'b0, 1'b0);
      issue(i2cm_pkg::MODE_READ_ACK, 8'h00, 1'b0, 1'b0);
      issue(i2cm_pkg::MODE_STOP, 8'h00, 1'b0, 1'b0);

      // Random traffic under three timings and three pacing patterns; the
      // first one includes a long receiver hold-off.
      set_timing(16'd1, 16'd1, 24'd7);
      run_random(RANDOM_TICKS, 1'b1);
      set_timing(16'd2, 16'd0, 24'd3);
      send_idle_pct = 76;
      rcv_idle_pct = 24;
      run_random(RANDOM_TICKS, 1'b0);
      set_timing(16'd3, 16'd2, 24'd1);
      send_idle_pct = 0;
      rcv_idle_pct = 0;
      run_random(RANDOM_TICKS, 1'b0);

      // The longest hold written but never taken: one byte asks for no hold
      // and the other one is refused.
      set_timing(16'd2, 16'd1, HOLD_MAX);
      issue(i2cm_pkg::MODE_START, 8'h00, 1'b0, 1'b0);
      issue(i2cm_pkg::MODE_WRITE, 8'h3C, 1'b0, 1'b0);
      issue(i2cm_pkg::MODE_WRITE, 8'hC3, 1'b1, 1'b1);
      issue(i2cm_pkg::MODE_STOP, 8'h00, 1'b0, 1'b0);

      wait_drained();
      repeat (20) @(posedge clock);
      if (line_state_q.size() != 0)
         report_mismatch("predicted results never popped", 0, line_state_q.size());
      $display("Run covered %0d ticks, %0d commands (%0d completed), %0d register writes.",
               n_ticks, n_cmds, n_done, n_reg_writes);
      $display("Written bytes: %0d acknowledged, %0d refused; %0d mismatches.",
               n_acked, n_nacked, n_errors);
      if (n_errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
